// File: sv/rdt_pkg.sv
// ----------------------------------------------------------------------------
// rdt_pkg
// Shared types and constants for the row dependency table: request and
// response payloads, operation and status codes, controller state and the
// command/status groups between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package rdt_pkg;

   // default sizing
   localparam int DEF_MAX_ROWS      = 256;
   localparam int DEF_SLOTS_PER_ROW = 16;

   // fixed field widths
   localparam int ROW_W    = 8;
   localparam int VALUE_W  = 9;
   localparam int COL_W    = 8;
   localparam int STATUS_W = 3;

   // reset value of the rows-in-use register
   localparam logic [VALUE_W-1:0] ROWS_IN_USE_RESET = 9'd256;

   typedef enum logic [1:0] {
      OP_SET_CAP = 2'd0,
      OP_INSERT  = 2'd1,
      OP_LIST    = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      RSP_SET       = 3'd0,
      RSP_INSERTED  = 3'd1,
      RSP_PRESENT   = 3'd2,
      RSP_FULL      = 3'd3,
      RSP_TOO_LARGE = 3'd4,
      RSP_BAD_ROW   = 3'd5,
      RSP_ENTRY     = 3'd6,
      RSP_EMPTY     = 3'd7
   } status_type;

   typedef struct packed {
      op_type             op;
      logic [ROW_W-1:0]   row;
      logic [VALUE_W-1:0] value;
   } req_payload_type;

   typedef struct packed {
      status_type       status;
      logic [COL_W-1:0] column;
      logic             last;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      S_CLEAR = 3'd0,
      S_IDLE  = 3'd1,
      S_READ  = 3'd2,
      S_EVAL  = 3'd3,
      S_LIST  = 3'd4
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic clear_step;
      logic capture;
      logic read;
      logic eval;
      logic list_step;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_done;
      logic out_free;
      logic list_needed;
      logic list_last;
   } dp_status_type;

endpackage

`default_nettype wire

// File: sv/rdt_ram.sv
// ----------------------------------------------------------------------------
// rdt_ram
// Generic single-write, single-read RAM with a registered read port that
// holds its data while no read is requested.
// ----------------------------------------------------------------------------
`default_nettype none

module rdt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: sv/rdt_datapath.sv
// ----------------------------------------------------------------------------
// rdt_datapath
// Request register, rows-in-use register, row metadata and slot memories,
// the parallel duplicate compare, the write-back and the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module rdt_datapath
   import rdt_pkg::*;
#(
   parameter int MAX_ROWS      = DEF_MAX_ROWS,
   parameter int SLOTS_PER_ROW = DEF_SLOTS_PER_ROW
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire req_payload_type    req_payload,
   input  wire logic               rsp_stall,
   output logic                    rsp_valid,
   output rsp_payload_type         rsp_payload,
   input  wire logic               csr_wr_en,
   input  wire logic [VALUE_W-1:0] csr_wr_data,
   input  wire dp_cmd_type         cmd,
   output dp_status_type           status
);

   localparam int AW  = $clog2(MAX_ROWS);
   localparam int CW  = $clog2(SLOTS_PER_ROW + 1);
   localparam int MW  = 2 * CW;
   localparam int SLW = SLOTS_PER_ROW * COL_W;

   // registers
   req_payload_type    req_ff, req_in;
   logic [VALUE_W-1:0] rows_in_use_ff, rows_in_use_in;
   logic [AW-1:0]      clr_addr_ff, clr_addr_in;
   rsp_payload_type    rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]      list_idx_ff, list_idx_in;

   // memory ports
   logic [AW-1:0]  row_addr;
   logic           meta_we;
   logic [AW-1:0]  meta_waddr;
   logic [MW-1:0]  meta_wdata;
   logic [MW-1:0]  meta_rd;
   logic           slot_we;
   logic [SLW-1:0] slot_rd;

   logic [SLOTS_PER_ROW-1:0][COL_W-1:0] slot_row;
   logic [SLOTS_PER_ROW-1:0][COL_W-1:0] slot_new;
   logic [CW-1:0]                       cur_cap;
   logic [CW-1:0]                       cur_fill;

   // evaluation results
   logic            present;
   logic            row_bad;
   logic            eval_has_result;
   status_type      eval_status;
   logic            eval_meta_we;
   logic [MW-1:0]   eval_meta_data;
   logic            eval_slot_we;
   logic            list_needed;
   logic            list_last;
   logic [COL_W-1:0] list_col;
   logic            out_free;

   assign row_addr = AW'(req_ff.row);
   assign cur_cap  = meta_rd[MW-1:CW];
   assign cur_fill = meta_rd[CW-1:0];
   assign slot_row = slot_rd;

   // row metadata: capacity and fill
   rdt_ram #(
      .WIDTH (MW),
      .DEPTH (MAX_ROWS)
   ) u_meta_ram (
      .clock   (clock),
      .wr_en   (meta_we),
      .wr_addr (meta_waddr),
      .wr_data (meta_wdata),
      .rd_en   (cmd.read),
      .rd_addr (row_addr),
      .rd_data (meta_rd)
   );

   // slot columns, one whole row per word
   rdt_ram #(
      .WIDTH (SLW),
      .DEPTH (MAX_ROWS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (row_addr),
      .wr_data (slot_new),
      .rd_en   (cmd.read),
      .rd_addr (row_addr),
      .rd_data (slot_rd)
   );

   // duplicate search over filled slots, new row with the column placed, and the listed column picked
   always_comb begin
      present  = 1'b0;
      slot_new = slot_row;
      list_col = '0;
      for (int k = 0; k < SLOTS_PER_ROW; k++) begin
         if ((32'(k) < 32'(cur_fill)) && (slot_row[k] == req_ff.value[COL_W-1:0])) begin
            present = 1'b1;
         end
         if (32'(k) == 32'(cur_fill)) begin
            slot_new[k] = req_ff.value[COL_W-1:0];
         end
         if (32'(k) == 32'(list_idx_ff)) begin
            list_col = slot_row[k];
         end
      end
   end

   // evaluate the captured request against the row read
   always_comb begin
      row_bad = (32'(req_ff.row) >= 32'(rows_in_use_ff)) ||
                (32'(req_ff.row) >= 32'(MAX_ROWS));
      eval_has_result = 1'b1;
      eval_status     = RSP_BAD_ROW;
      eval_meta_we    = 1'b0;
      eval_meta_data  = {cur_cap, cur_fill};
      eval_slot_we    = 1'b0;
      list_needed     = 1'b0;
      if (req_ff.op == OP_NONE) begin
         eval_has_result = 1'b0;
      end else if (!row_bad) begin
         case (req_ff.op)
            OP_SET_CAP: begin
               if ((32'(req_ff.value) > 32'(rows_in_use_ff)) ||
                   (32'(req_ff.value) > 32'(SLOTS_PER_ROW))) begin
                  eval_status = RSP_TOO_LARGE;
               end else begin
                  eval_status    = RSP_SET;
                  eval_meta_we   = 1'b1;
                  eval_meta_data = {CW'(req_ff.value), {CW{1'b0}}};
               end
            end
            OP_INSERT: begin
               if (req_ff.value[VALUE_W-1]) begin
                  eval_status = RSP_TOO_LARGE;
               end else if (present) begin
                  eval_status = RSP_PRESENT;
               end else if ((cur_fill >= cur_cap) ||
                            (32'(cur_fill) >= 32'(SLOTS_PER_ROW))) begin
                  eval_status = RSP_FULL;
               end else begin
                  eval_status    = RSP_INSERTED;
                  eval_meta_we   = 1'b1;
                  eval_slot_we   = 1'b1;
                  eval_meta_data = {cur_cap, cur_fill + CW'(1)};
               end
            end
            OP_LIST: begin
               if (cur_fill == '0) begin
                  eval_status = RSP_EMPTY;
               end else begin
                  eval_has_result = 1'b0;
                  list_needed     = 1'b1;
               end
            end
            default: begin
               eval_has_result = 1'b0;
            end
         endcase
      end
   end

   // memory write selection: clearing pass or write-back
   always_comb begin
      meta_we    = cmd.clear_step || (cmd.eval && eval_meta_we);
      meta_waddr = cmd.clear_step ? clr_addr_ff : row_addr;
      meta_wdata = cmd.clear_step ? '0 : eval_meta_data;
      slot_we    = cmd.eval && eval_slot_we;
   end

   assign list_last = (list_idx_ff == (cur_fill - CW'(1)));
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // next values
   always_comb begin
      req_in         = cmd.capture ? req_payload : req_ff;
      rows_in_use_in = csr_wr_en ? csr_wr_data : rows_in_use_ff;
      clr_addr_in    = cmd.clear_step ? clr_addr_ff + AW'(1) : clr_addr_ff;
      list_idx_in    = list_idx_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      if (cmd.eval) begin
         list_idx_in = '0;
         if (eval_has_result) begin
            rsp_in       = '{status: eval_status, column: '0, last: 1'b1};
            rsp_valid_in = 1'b1;
         end
      end
      if (cmd.list_step) begin
         list_idx_in  = list_idx_ff + CW'(1);
         rsp_in       = '{status: RSP_ENTRY, column: list_col, last: list_last};
         rsp_valid_in = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_in_use_ff <= ROWS_IN_USE_RESET;
         clr_addr_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
         list_idx_ff    <= '0;
      end else begin
         rows_in_use_ff <= rows_in_use_in;
         clr_addr_ff    <= clr_addr_in;
         rsp_valid_ff   <= rsp_valid_in;
         list_idx_ff    <= list_idx_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign status = '{
      clear_done:  (clr_addr_ff == AW'(MAX_ROWS - 1)),
      out_free:    out_free,
      list_needed: list_needed,
      list_last:   list_last
   };

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

// File: sv/rdt_controller.sv
// ----------------------------------------------------------------------------
// rdt_controller
// Sequencer for the row dependency table: clearing pass after reset, then
// capture, row read, evaluate with write-back, and entry-by-entry listing.
// ----------------------------------------------------------------------------
`default_nettype none

module rdt_controller
   import rdt_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire dp_status_type status,
   output dp_cmd_type         cmd
);

   state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (status.clear_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) state_in = S_READ;
         end
         S_READ: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (status.out_free) state_in = status.list_needed ? S_LIST : S_IDLE;
         end
         S_LIST: begin
            if (status.out_free && status.list_last) state_in = S_IDLE;
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   // commands
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
         end
         S_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         S_READ: begin
            cmd.read = 1'b1;
         end
         S_EVAL: begin
            cmd.eval = status.out_free;
         end
         S_LIST: begin
            cmd.list_step = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/row_dependency_table_unit.sv
// ----------------------------------------------------------------------------
// row_dependency_table_unit
// Per-row column table (sparsity pattern) with set-capacity, insert and
// list requests, reporting each outcome as a status code.
// ----------------------------------------------------------------------------
// After reset the unit runs a clearing pass over the row metadata memory,
// one row per cycle over all MAX_ROWS rows, and stalls requests meanwhile
// (csr writes are taken at any time). It then handles one request at a
// time: a set-capacity, insert or empty/out-of-range request passes
// through capture, one read of the whole row from the row-wide memories,
// then evaluation with write-back and a load of the response register;
// a list request on a non-empty row then sends its entries one per cycle
// from the row word read, whenever the response output is not stalled.
// The next request is taken the cycle after the last response is loaded,
// even while that response waits on rsp_stall; a stalled response delays
// evaluation of the following request. Op code 3 is accepted and gives no response.
// ----------------------------------------------------------------------------
`default_nettype none

module row_dependency_table_unit
   import rdt_pkg::*;
#(
   parameter int MAX_ROWS      = DEF_MAX_ROWS,
   parameter int SLOTS_PER_ROW = DEF_SLOTS_PER_ROW
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire req_payload_type    req_payload,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output rsp_payload_type         rsp_payload,
   input  wire logic               csr_wr_en,
   input  wire logic [VALUE_W-1:0] csr_wr_data
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // sequencer
   rdt_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   // storage and evaluation
   rdt_datapath #(
      .MAX_ROWS      (MAX_ROWS),
      .SLOTS_PER_ROW (SLOTS_PER_ROW)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (dp_cmd),
      .status      (dp_status)
   );

   // one request in flight: an accepted request blocks the next cycle
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while previous one still in flight");

   // evaluation never overwrites a response still held by the consumer
   a_eval_output_free: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.eval || dp_cmd.list_step) |-> (!rsp_valid || !rsp_stall))
      else $error("response register loaded while stalled");

   // no request is taken during the clearing pass
   a_clear_blocks_requests: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.clear_step |-> (req_stall && !dp_cmd.capture))
      else $error("request accepted during clearing pass");

   // a row read is always followed by its evaluation slot
   a_read_then_eval: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.read |=> (!dp_cmd.read && !dp_cmd.capture && req_stall))
      else $error("row read not followed by evaluation");

endmodule

`default_nettype wire

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for row_dependency_table_unit. A clocked driver sends
// requests from a backlog that the main sequence fills; a shadow copy of the
// row table predicts the responses of each accepted request, and a clocked
// monitor checks every accepted response against the oldest prediction.
// Runs directed corner requests, then random capacity/insert/list sequences
// under several rows-in-use settings and sender/receiver idling patterns.
// ----------------------------------------------------------------------------
module testbench;
   import rdt_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_ROWS     = DEF_MAX_ROWS;
   localparam int ROW_SLOTS      = DEF_SLOTS_PER_ROW;
   localparam int SETTLE_CYCLES  = 40;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int WATCHDOG_LIMIT = 5000;

   logic               clock;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   req_payload_type    req_payload = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   rsp_payload_type    rsp_payload;
   logic               csr_wr_en = 1'b0;
   logic [VALUE_W-1:0] csr_wr_data = '0;

   // shadow of the row table
   logic [VALUE_W-1:0] rows_in_use_shadow;
   logic [4:0]         capacity_shadow [TABLE_ROWS];
   logic [4:0]         fill_shadow [TABLE_ROWS];
   logic [COL_W-1:0]   column_shadow [TABLE_ROWS][ROW_SLOTS];

   req_payload_type    request_backlog [$];
   rsp_payload_type    table_responses_due [$];

   int                 sender_idle_pct = 0;
   int                 receiver_stall_pct = 0;
   logic               holdoff_armed = 1'b0;
   int                 holdoff_count;
   logic               holdoff_active;
   int                 stuck_cycles;

   int                 error_count = 0;
   int                 accepted_requests = 0;
   int                 checked_responses = 0;
   int                 full_row_listings = 0;
   rsp_payload_type    oldest_due;

   row_dependency_table_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // push one response onto the list of those owed by the table
   function automatic void owe_response(status_type status, logic [COL_W-1:0] column,
                                        logic last);
      rsp_payload_type r;
      r.status = status;
      r.column = column;
      r.last   = last;
      table_responses_due.push_back(r);
   endfunction

   // update the shadow table for one accepted request, queue what it returns
   function automatic void apply_table_request(req_payload_type r);
      int fill;
      int k;
      if (r.op == OP_NONE) return;
      if (r.row >= rows_in_use_shadow || r.row >= TABLE_ROWS) begin
         owe_response(RSP_BAD_ROW, '0, 1'b1);
         return;
      end
      fill = fill_shadow[r.row];
      case (r.op)
         OP_SET_CAP: begin
            if (r.value > rows_in_use_shadow || r.value > ROW_SLOTS) begin
               owe_response(RSP_TOO_LARGE, '0, 1'b1);
            end else begin
               capacity_shadow[r.row] = r.value[4:0];
               fill_shadow[r.row] = '0;
               owe_response(RSP_SET, '0, 1'b1);
            end
         end
         OP_INSERT: begin
            if (r.value > 255) begin
               owe_response(RSP_TOO_LARGE, '0, 1'b1);
               return;
            end
            for (k = 0; k < fill && k < ROW_SLOTS; k++) begin
               if (column_shadow[r.row][k] == r.value[COL_W-1:0]) begin
                  owe_response(RSP_PRESENT, '0, 1'b1);
                  return;
               end
            end
            if (fill >= capacity_shadow[r.row] || fill >= ROW_SLOTS) begin
               owe_response(RSP_FULL, '0, 1'b1);
            end else begin
               column_shadow[r.row][fill] = r.value[COL_W-1:0];
               fill_shadow[r.row] = 5'(fill + 1);
               owe_response(RSP_INSERTED, '0, 1'b1);
            end
         end
         default: begin
            if (fill == 0) begin
               owe_response(RSP_EMPTY, '0, 1'b1);
               return;
            end
            if (fill > ROW_SLOTS) fill = ROW_SLOTS;
            if (fill == ROW_SLOTS) full_row_listings++;
            for (k = 0; k < fill; k++)
               owe_response(RSP_ENTRY, column_shadow[r.row][k], k + 1 == fill);
         end
      endcase
   endfunction

   function automatic void queue_request(op_type op, logic [ROW_W-1:0] row,
                                         logic [VALUE_W-1:0] value);
      req_payload_type r;
      r.op    = op;
      r.row   = row;
      r.value = value;
      request_backlog.push_back(r);
   endfunction

   // random traffic: mostly build-and-list sequences on a few rows, some noise
   function automatic void queue_random_requests(int target);
      int made;
      int span;
      int row;
      int inserts;
      int col_base;
      int cap;
      int value;
      int op;
      made = 0;
      span = (rows_in_use_shadow == 0 || rows_in_use_shadow > TABLE_ROWS) ?
             TABLE_ROWS : int'(rows_in_use_shadow);
      while (made < target) begin
         if ($urandom_range(99) < 70) begin
            case ($urandom_range(3))
               0, 1:    row = $urandom_range(0, (span < 4 ? span : 4) - 1);
               2:       row = span - 1;
               default: row = $urandom_range(0, span - 1);
            endcase
            if ($urandom_range(3) != 0) begin
               cap = ($urandom_range(2) == 0) ? ROW_SLOTS : $urandom_range(0, ROW_SLOTS);
               queue_request(OP_SET_CAP, row[ROW_W-1:0], cap[VALUE_W-1:0]);
               made++;
            end
            inserts = $urandom_range(1, ROW_SLOTS + 2);
            col_base = $urandom_range(0, 255);
            repeat (inserts) begin
               if ($urandom_range(11) == 0)
                  value = $urandom_range(256, 511);
               else
                  value = (col_base + $urandom_range(0, inserts + 2)) % 256;
               queue_request(OP_INSERT, row[ROW_W-1:0], value[VALUE_W-1:0]);
            end
            queue_request(OP_LIST, row[ROW_W-1:0], 9'($urandom_range(0, 511)));
            made += inserts + 1;
         end else begin
            op    = $urandom_range(0, 3);
            row   = $urandom_range(0, 255);
            value = $urandom_range(0, 511);
            queue_request(op_type'(op), row[ROW_W-1:0], value[VALUE_W-1:0]);
            if (op != OP_NONE) made++;
         end
      end
   endfunction

   // wait until every request is sent and answered, then let the unit settle
   task automatic wait_until_drained();
      do @(negedge clock);
      while (request_backlog.size() != 0 || req_valid || table_responses_due.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_rows_in_use(logic [VALUE_W-1:0] rows);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= rows;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      rows_in_use_shadow = rows;
      @(negedge clock);
   endtask

   task automatic start_phase(logic [VALUE_W-1:0] rows, int idle_pct, int stall_pct);
      wait_until_drained();
      write_rows_in_use(rows);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            apply_table_request(req_payload);
            accepted_requests++;
         end
         if (!req_valid || !req_stall) begin
            if (request_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_valid   <= 1'b1;
               req_payload <= request_backlog.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off, counted here once armed
   always @(posedge clock) begin
      if (reset) begin
         holdoff_count <= 0;
      end else if (holdoff_active) begin
         holdoff_count <= holdoff_count + 1;
      end
   end

   assign holdoff_active = holdoff_armed && holdoff_count < HOLDOFF_CYCLES;

   // response monitor and receiver stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            checked_responses++;
            if (table_responses_due.size() == 0) begin
               error_count++;
               $display("%0t: unexpected response status %0d column %0d last %0d",
                        $time, rsp_payload.status, rsp_payload.column, rsp_payload.last);
            end else begin
               oldest_due = table_responses_due.pop_front();
               if (rsp_payload.status !== oldest_due.status ||
                   rsp_payload.column !== oldest_due.column ||
                   rsp_payload.last !== oldest_due.last) begin
                  error_count++;
                  $display("%0t: response mismatch: expected status %0d column %0d last %0d,",
                           $time, oldest_due.status, oldest_due.column, oldest_due.last,
                           " got status %0d column %0d last %0d",
                           rsp_payload.status, rsp_payload.column, rsp_payload.last);
               end
            end
         end
         rsp_stall <= holdoff_active || ($urandom_range(99) < receiver_stall_pct);
      end
   end

   // watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
         if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no request or response moved for %0d cycles", $time,
                     WATCHDOG_LIMIT);
            $display("FAILURE");
            $finish;
         end
      end
   end

   // main sequence
   initial begin
      rows_in_use_shadow = ROWS_IN_USE_RESET;
      for (int r = 0; r < TABLE_ROWS; r++) begin
         capacity_shadow[r] = '0;
         fill_shadow[r] = '0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed corners at full size
      write_rows_in_use(9'd256);
      queue_request(OP_LIST, 8'd0, 9'd0);       // empty row
      queue_request(OP_INSERT, 8'd0, 9'd5);     // zero capacity after reset
      queue_request(OP_SET_CAP, 8'd0, 9'd17);   // above slot count
      queue_request(OP_SET_CAP, 8'd0, 9'd511);
      queue_request(OP_SET_CAP, 8'd255, 9'd16);
      queue_request(OP_INSERT, 8'd255, 9'd255);
      queue_request(OP_INSERT, 8'd255, 9'd0);
      queue_request(OP_INSERT, 8'd255, 9'd255); // duplicate
      queue_request(OP_INSERT, 8'd255, 9'd256); // column too wide
      queue_request(OP_INSERT, 8'd255, 9'd511);
      queue_request(OP_SET_CAP, 8'd1, 9'd2);
      queue_request(OP_INSERT, 8'd1, 9'd10);
      queue_request(OP_INSERT, 8'd1, 9'd20);
      queue_request(OP_INSERT, 8'd1, 9'd30);    // row full
      queue_request(OP_INSERT, 8'd1, 9'd20);    // duplicate in a full row
      queue_request(OP_LIST, 8'd1, 9'd0);
      queue_request(OP_LIST, 8'd255, 9'd511);
      queue_request(OP_NONE, 8'd255, 9'd511);   // ignored selector
      queue_request(OP_SET_CAP, 8'd0, 9'd0);

      // directed corners on a small system
      start_phase(9'd4, 0, 0);
      queue_request(OP_SET_CAP, 8'd3, 9'd4);
      queue_request(OP_SET_CAP, 8'd3, 9'd5);    // above rows in use
      queue_request(OP_INSERT, 8'd4, 9'd1);     // row out of range
      queue_request(OP_LIST, 8'd255, 9'd0);
      start_phase(9'd0, 0, 0);
      queue_request(OP_LIST, 8'd0, 9'd0);       // every row out of range
      queue_request(OP_NONE, 8'd0, 9'd0);

      // random traffic under several sizes and idling patterns
      start_phase(9'd256, 0, 0);
      queue_random_requests(44);
      start_phase(9'd16, 82, 0);
      queue_random_requests(34);
      start_phase(9'd1, 0, 82);
      queue_random_requests(24);
      start_phase(9'd511, 35, 35);
      queue_random_requests(34);

      // back-pressure: receiver holds off while the sender keeps offering
      start_phase(9'd8, 0, 0);
      holdoff_armed = 1'b1;
      queue_random_requests(19);
      // sender pause until every owed response is back
      wait_until_drained();
      queue_random_requests(14);

      start_phase(9'd0, 20, 20);
      queue_random_requests(5);
      start_phase(9'd256, 20, 20);
      queue_random_requests(19);

      wait_until_drained();
      $display("covered %0d requests and %0d responses over sizes 0 to 511,",
               accepted_requests, checked_responses);
      $display("with %0d full-row listings and long back-pressure", full_row_listings);
      if (error_count == 0 && table_responses_due.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
